### rtl/mptc_pkg.sv
package mptc_pkg;

    typedef logic [1:0] op_t;
    localparam op_t OP_TICK     = 2'd0;
    localparam op_t OP_SET_DUTY = 2'd1;
    localparam op_t OP_SET_POS  = 2'd2;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_POLE_CNT     = 3'd0;
    localparam reg_idx_t REG_LEAD_DEG     = 3'd1;
    localparam reg_idx_t REG_DEADBAND     = 3'd2;
    localparam reg_idx_t REG_VEL_TICKS    = 3'd3;
    localparam reg_idx_t REG_VEL_SCALE    = 3'd4;
    localparam reg_idx_t REG_DUTY_LIMIT   = 3'd5;
    localparam reg_idx_t REG_DEFAULT_DUTY = 3'd6;

    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 64;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 112;

    typedef logic [1:0] dir_t;
    localparam dir_t DIR_STOP = 2'b00;
    localparam dir_t DIR_FWD  = 2'b01;
    localparam dir_t DIR_REV  = 2'b11;

    // reciprocal constants for division by constants
    localparam logic [31:0] DIV10K_MAGIC  = 32'd3518437209; // shift 45
    localparam logic [30:0] DIV100_MAGIC  = 31'd1374389535; // shift 37
    localparam logic [25:0] DIV3600_MAGIC = 26'd38177488;   // shift 37, n < 2^25
    localparam logic [9:0]  ELEC_SCALE    = 10'd573;
    localparam logic [11:0] FULL_TURN     = 12'd3600;
    localparam logic [11:0] STEP_SPAN     = 12'd600;

    typedef struct packed {
        logic [3:0]  pole_pair_cnt;
        logic [8:0]  lead_deg;
        logic [15:0] deadband_crad;
        logic [7:0]  vel_update_ticks;
        logic [15:0] vel_scale;
        logic [15:0] duty_limit;
        logic [14:0] default_duty;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        pole_pair_cnt:    4'd6,
        lead_deg:         9'd110,
        deadband_crad:    16'd500,
        vel_update_ticks: 8'd5,
        vel_scale:        16'd1000,
        duty_limit:       16'd799,
        default_duty:     15'd150
    };

    typedef struct packed {
        logic accept;
        logic unwrap;
        logic vel;
        logic div;
        logic comm;
        logic scale;
        logic pole;
        logic modq;
        logic load_out;
    } cmd_t;

    function automatic logic [14:0] abs_sat16(input logic [15:0] d);
        logic [15:0] n;
        begin
            n = 16'd0 - d;
            if (d == 16'h8000) begin
                abs_sat16 = 15'h7fff;
            end else if (d[15]) begin
                abs_sat16 = n[14:0];
            end else begin
                abs_sat16 = d[14:0];
            end
        end
    endfunction

    function automatic logic [2:0] hall_of(input logic [2:0] step);
        begin
            case (step)
                3'd0:    hall_of = 3'b110;
                3'd1:    hall_of = 3'b100;
                3'd2:    hall_of = 3'b101;
                3'd3:    hall_of = 3'b001;
                3'd4:    hall_of = 3'b011;
                default: hall_of = 3'b010;
            endcase
        end
    endfunction

endpackage

### rtl/mptc_cfg.sv
module mptc_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  mptc_pkg::reg_idx_t   wr_index,
    input  logic [15:0]          wr_data,
    output mptc_pkg::cfg_t       cfg
);
    import mptc_pkg::*;

    cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_POLE_CNT:     cfg_next.pole_pair_cnt    = wr_data[3:0];
                REG_LEAD_DEG:     cfg_next.lead_deg         = wr_data[8:0];
                REG_DEADBAND:     cfg_next.deadband_crad    = wr_data;
                REG_VEL_TICKS:    cfg_next.vel_update_ticks = wr_data[7:0];
                REG_VEL_SCALE:    cfg_next.vel_scale        = wr_data;
                REG_DUTY_LIMIT:   cfg_next.duty_limit       = wr_data;
                REG_DEFAULT_DUTY: cfg_next.default_duty     = wr_data[14:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/mptc_ctrl.sv
module mptc_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  mptc_pkg::op_t   op,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output mptc_pkg::cmd_t  cmd
);
    import mptc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UNWRAP,
        ST_VEL,
        ST_DIV,
        ST_COMM,
        ST_SCALE,
        ST_POLE,
        ST_MODQ,
        ST_STEP
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd          = '0;
        cmd.accept   = s_tvalid && (state_reg == ST_IDLE);
        cmd.unwrap   = (state_reg == ST_UNWRAP);
        cmd.vel      = (state_reg == ST_VEL);
        cmd.div      = (state_reg == ST_DIV);
        cmd.comm     = (state_reg == ST_COMM);
        cmd.scale    = (state_reg == ST_SCALE);
        cmd.pole     = (state_reg == ST_POLE);
        cmd.modq     = (state_reg == ST_MODQ);
        cmd.load_out = (state_reg == ST_STEP) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && op == OP_TICK) begin
                    state_next = ST_UNWRAP;
                end
            end
            ST_UNWRAP: state_next = ST_VEL;
            ST_VEL:    state_next = ST_DIV;
            ST_DIV:    state_next = ST_COMM;
            ST_COMM:   state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_POLE;
            ST_POLE:   state_next = ST_MODQ;
            ST_MODQ:   state_next = ST_STEP;
            ST_STEP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
        m_tvalid_next = (m_tvalid_reg && !m_tready) || cmd.load_out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

`ifndef SYNTHESIS
    a_tick_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && op == OP_TICK) |=> state_reg == ST_UNWRAP)
        else $error("tick item did not start the sequence");

    a_set_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && op != OP_TICK) |=> state_reg == ST_IDLE)
        else $error("set command left idle");

    a_step_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP && m_tvalid_reg && !m_tready)
        |=> (state_reg == ST_STEP && m_tvalid_reg))
        else $error("result dropped while output stalled");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.unwrap, cmd.vel, cmd.div, cmd.comm,
                  cmd.scale, cmd.pole, cmd.modq, cmd.load_out}))
        else $error("more than one datapath command");
`endif

endmodule

### rtl/mptc_dpath.sv
module mptc_dpath (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mptc_pkg::cmd_t        cmd,
    input  mptc_pkg::cfg_t        cfg,
    input  mptc_pkg::op_t         op,
    input  logic signed [10:0]    shaft_angle,
    input  logic signed [15:0]    duty_value,
    input  logic signed [31:0]    target_value,
    output logic [15:0]           pwm_compare,
    output logic signed [15:0]    applied_duty,
    output logic [2:0]            hall_bits,
    output logic [2:0]            comm_step,
    output logic signed [1:0]     drive_direction,
    output logic signed [31:0]    position_out,
    output logic signed [31:0]    velocity_out,
    output logic                  position_reached
);
    import mptc_pkg::*;

    // tracker state
    logic [10:0] prev_angle_reg, prev_angle_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] vel_reg, vel_next;
    logic [31:0] last_pos_reg, last_pos_next;
    logic [7:0]  tick_cnt_reg, tick_cnt_next;
    logic        pmode_reg, pmode_next;
    logic [31:0] target_reg, target_next;
    logic [15:0] sduty_reg, sduty_next;

    // work registers
    logic [10:0] angle_reg;
    logic        vupd_reg;
    logic [15:0] duty_reg;
    dir_t        dir_reg;
    logic [15:0] mag_reg;
    logic [17:0] q10k_reg;
    logic        vneg_reg;
    logic [26:0] t_reg;
    logic        tneg_reg;
    logic [20:0] u_reg;
    logic        uneg_reg;
    logic [24:0] eabs_reg;
    logic        eneg_reg;
    logic [12:0] q3600_reg;

    // output registers
    logic [15:0] out_pwm_reg;
    logic [15:0] out_duty_reg;
    logic [2:0]  out_hall_reg;
    logic [2:0]  out_step_reg;
    dir_t        out_dir_reg;
    logic [31:0] out_pos_reg;
    logic [31:0] out_vel_reg;
    logic        out_reached_reg;

    // unwrap
    logic signed [11:0] delta_raw, delta_fix;
    logic [7:0]         cnt_inc;
    logic               vupd_now;

    always_comb begin
        delta_raw = $signed({angle_reg[10], angle_reg}) -
                    $signed({prev_angle_reg[10], prev_angle_reg});
        delta_fix = delta_raw;
        if (delta_raw > 12'sd314) begin
            delta_fix = delta_raw - 12'sd628;
        end else if (delta_raw < -12'sd314) begin
            delta_fix = delta_raw + 12'sd628;
        end
        cnt_inc  = tick_cnt_reg + 8'd1;
        vupd_now = (cnt_inc >= cfg.vel_update_ticks);
    end

    // velocity and control rule
    logic [31:0]        pos_diff;
    logic [47:0]        vel_prod;
    logic [31:0]        err;
    logic signed [32:0] err_x, db_x;
    logic               err_gt, err_lt;
    logic               sduty_pos;
    logic [15:0]        sduty_abs;
    logic [15:0]        duty_sel;
    dir_t               dir_sel;

    always_comb begin
        pos_diff  = pos_reg - last_pos_reg;
        vel_prod  = {16'd0, pos_diff} * {32'd0, cfg.vel_scale};
        err       = target_reg - pos_reg;
        err_x     = $signed({err[31], err});
        db_x      = $signed({17'd0, cfg.deadband_crad});
        err_gt    = err_x > db_x;
        err_lt    = err_x < -db_x;
        sduty_pos = !sduty_reg[15] && (sduty_reg != 16'd0);
        sduty_abs = {1'b0, abs_sat16(sduty_reg)};
        duty_sel  = 16'd0;
        dir_sel   = DIR_STOP;
        if (pmode_reg) begin
            if (err_gt) begin
                duty_sel = sduty_abs;
                dir_sel  = DIR_FWD;
            end else if (err_lt) begin
                duty_sel = sduty_pos ? 16'd0 - sduty_reg : sduty_reg;
                dir_sel  = DIR_REV;
            end
        end else begin
            duty_sel = sduty_reg;
            if (sduty_pos) begin
                dir_sel = DIR_FWD;
            end else if (sduty_reg[15]) begin
                dir_sel = DIR_REV;
            end
        end
    end

    // velocity / 10000 and pwm clamp
    logic [31:0] vel_abs;
    logic [63:0] div10k_prod;
    logic [15:0] duty_mag;
    logic [15:0] mag_sel;

    always_comb begin
        vel_abs     = vel_reg[31] ? 32'd0 - vel_reg : vel_reg;
        div10k_prod = {32'd0, vel_abs} * {32'd0, DIV10K_MAGIC};
        duty_mag    = {1'b0, abs_sat16(duty_reg)};
        mag_sel     = (duty_mag > cfg.duty_limit) ? cfg.duty_limit : duty_mag;
    end

    // predicted angle times 573
    logic [19:0] q_ext, q_signed, comm, comm_abs;
    logic [26:0] t_prod;

    always_comb begin
        q_ext    = {2'b00, q10k_reg};
        q_signed = vneg_reg ? 20'd0 - q_ext : q_ext;
        comm     = {{9{angle_reg[10]}}, angle_reg} +
                   ((dir_reg != DIR_STOP) ? q_signed : 20'd0);
        comm_abs = comm[19] ? 20'd0 - comm : comm;
        t_prod   = {9'd0, comm_abs[17:0]} * {17'd0, ELEC_SCALE};
    end

    // / 100, truncated toward zero
    logic [57:0] div100_prod;

    assign div100_prod = {31'd0, t_reg} * {27'd0, DIV100_MAGIC};

    // times pole pairs, plus advance (minus advance when not forward)
    logic [21:0]        u_ext, u_signed;
    logic signed [26:0] e_pp;
    logic [12:0]        adv10;
    logic [26:0]        e_sum, e_abs;

    always_comb begin
        u_ext    = {1'b0, u_reg};
        u_signed = uneg_reg ? 22'd0 - u_ext : u_ext;
        e_pp     = $signed({{5{u_signed[21]}}, u_signed}) *
                   $signed({23'd0, cfg.pole_pair_cnt});
        adv10    = {4'd0, cfg.lead_deg} * 13'd10;
        // a stopped drive takes the negative advance
        e_sum    = (dir_reg == DIR_FWD) ? e_pp + {14'd0, adv10} : e_pp - {14'd0, adv10};
        e_abs    = e_sum[26] ? 27'd0 - e_sum : e_sum;
    end

    // modulo 3600 and step
    logic [50:0] div3600_prod;
    logic [24:0] qm, r_wide;
    logic [11:0] r_raw, r_mod;
    logic [2:0]  step_sel;

    always_comb begin
        div3600_prod = {26'd0, eabs_reg} * {25'd0, DIV3600_MAGIC};
        qm           = {12'd0, q3600_reg} * {13'd0, FULL_TURN};
        r_wide       = eabs_reg - qm;
        r_raw        = r_wide[11:0];
        r_mod        = (eneg_reg && r_raw != 12'd0) ? FULL_TURN - r_raw : r_raw;
        if (r_mod >= 12'(5 * STEP_SPAN)) begin
            step_sel = 3'd5;
        end else if (r_mod >= 12'(4 * STEP_SPAN)) begin
            step_sel = 3'd4;
        end else if (r_mod >= 12'(3 * STEP_SPAN)) begin
            step_sel = 3'd3;
        end else if (r_mod >= 12'(2 * STEP_SPAN)) begin
            step_sel = 3'd2;
        end else if (r_mod >= STEP_SPAN) begin
            step_sel = 3'd1;
        end else begin
            step_sel = 3'd0;
        end
    end

    // tracker state update
    always_comb begin
        prev_angle_next = prev_angle_reg;
        pos_next        = pos_reg;
        vel_next        = vel_reg;
        last_pos_next   = last_pos_reg;
        tick_cnt_next   = tick_cnt_reg;
        pmode_next      = pmode_reg;
        target_next     = target_reg;
        sduty_next      = sduty_reg;
        if (cmd.accept) begin
            case (op)
                OP_SET_DUTY: begin
                    sduty_next = duty_value;
                    pmode_next = 1'b0;
                end
                OP_SET_POS: begin
                    target_next = target_value;
                    pmode_next  = 1'b1;
                    if (sduty_reg == 16'd0) begin
                        sduty_next = {1'b0, cfg.default_duty};
                    end
                end
                default: ;
            endcase
        end
        if (cmd.unwrap) begin
            pos_next        = pos_reg + {{20{delta_fix[11]}}, delta_fix};
            prev_angle_next = angle_reg;
            tick_cnt_next   = vupd_now ? 8'd0 : cnt_inc;
        end
        if (cmd.vel && vupd_reg) begin
            vel_next      = vel_prod[31:0];
            last_pos_next = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_angle_reg <= '0;
            pos_reg        <= '0;
            vel_reg        <= '0;
            last_pos_reg   <= '0;
            tick_cnt_reg   <= '0;
            pmode_reg      <= 1'b0;
            target_reg     <= '0;
            sduty_reg      <= '0;
        end else begin
            prev_angle_reg <= prev_angle_next;
            pos_reg        <= pos_next;
            vel_reg        <= vel_next;
            last_pos_reg   <= last_pos_next;
            tick_cnt_reg   <= tick_cnt_next;
            pmode_reg      <= pmode_next;
            target_reg     <= target_next;
            sduty_reg      <= sduty_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            angle_reg <= shaft_angle;
        end
        if (cmd.unwrap) begin
            vupd_reg <= vupd_now;
        end
        if (cmd.vel) begin
            duty_reg <= duty_sel;
            dir_reg  <= dir_sel;
        end
        if (cmd.div) begin
            q10k_reg <= div10k_prod[62:45];
            vneg_reg <= vel_reg[31];
            mag_reg  <= mag_sel;
        end
        if (cmd.comm) begin
            t_reg    <= t_prod;
            tneg_reg <= comm[19];
        end
        if (cmd.scale) begin
            u_reg    <= div100_prod[57:37];
            uneg_reg <= tneg_reg;
        end
        if (cmd.pole) begin
            eabs_reg <= e_abs[24:0];
            eneg_reg <= e_sum[26];
        end
        if (cmd.modq) begin
            q3600_reg <= div3600_prod[49:37];
        end
        if (cmd.load_out) begin
            out_pwm_reg     <= mag_reg;
            out_duty_reg    <= duty_reg;
            out_hall_reg    <= hall_of(step_sel);
            out_step_reg    <= step_sel;
            out_dir_reg     <= dir_reg;
            out_pos_reg     <= pos_reg;
            out_vel_reg     <= vel_reg;
            out_reached_reg <= pmode_reg && (dir_reg == DIR_STOP);
        end
    end

    assign pwm_compare      = out_pwm_reg;
    assign applied_duty     = out_duty_reg;
    assign hall_bits        = out_hall_reg;
    assign comm_step        = out_step_reg;
    assign drive_direction  = out_dir_reg;
    assign position_out     = out_pos_reg;
    assign velocity_out     = out_vel_reg;
    assign position_reached = out_reached_reg;

`ifndef SYNTHESIS
    a_pwm_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> out_pwm_reg <= $past(cfg.duty_limit))
        else $error("pwm compare above limit");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> out_step_reg <= 3'd5)
        else $error("commutation step out of range");

    a_reached_no_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> (!out_reached_reg || out_duty_reg == 16'd0))
        else $error("duty applied inside deadband");
`endif

endmodule

### rtl/motor_position_tracker_commutator.sv
// Multi-turn position tracker with six-step commutation. Each input item is a tick, a
// set-duty or a set-position command, selected by s_tuser. Set commands update the stored
// duty, target and mode and produce no result. A tick unwraps the single-turn
// angle into a 32-bit position, refreshes velocity every vel_update_ticks ticks, applies
// the deadband position rule or plain duty control and returns one result with the PWM
// compare, the applied duty, the hall pattern and commutation step, direction, position,
// velocity and an in-deadband flag. From acceptance to the result register the controller
// walks a tick through eight datapath steps (unwrap, velocity, and the chain of reciprocal
// multiplies for /10000, /100, pole pairs and modulo 3600); no new item is taken until
// the tick has loaded the result register. The result register frees the input side
// as soon as it is loaded; a held result stalls only the last step. Configuration writes
// are always taken (cfg_ready high) and must be made while no tick is in flight.
module motor_position_tracker_commutator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // shaft_angle[10:0], duty_value[26:11], target_value[58:27]
    input  logic [mptc_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [mptc_pkg::S_TUSER_W-1:0]     s_tuser,   // operation[1:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pwm_compare[15:0], applied_duty[31:16], hall_bits[34:32], comm_step[37:35],
    // drive_direction[39:38], position_out[71:40], velocity_out[103:72],
    // position_reached[104]
    output logic [mptc_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  mptc_pkg::reg_idx_t                 cfg_index,
    input  logic [mptc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mptc_pkg::*;

    cfg_t               cfg;
    cmd_t               cmd;
    op_t                op;
    logic [15:0]        pwm_compare;
    logic signed [15:0] applied_duty;
    logic [2:0]         hall_bits;
    logic [2:0]         comm_step;
    logic signed [1:0]  drive_direction;
    logic signed [31:0] position_out;
    logic signed [31:0] velocity_out;
    logic               position_reached;

    assign op        = s_tuser;
    assign cfg_ready = 1'b1;

    mptc_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    mptc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (op),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mptc_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cfg              (cfg),
        .op               (op),
        .shaft_angle      (s_tdata[10:0]),
        .duty_value       (s_tdata[26:11]),
        .target_value     (s_tdata[58:27]),
        .pwm_compare      (pwm_compare),
        .applied_duty     (applied_duty),
        .hall_bits        (hall_bits),
        .comm_step        (comm_step),
        .drive_direction  (drive_direction),
        .position_out     (position_out),
        .velocity_out     (velocity_out),
        .position_reached (position_reached)
    );

    assign m_tdata = {7'd0, position_reached, velocity_out, position_out, drive_direction,
                      comm_step, hall_bits, applied_duty, pwm_compare};

endmodule
